// ===== sv/cdq_pkg.sv =====
// Shared types and constants for the circular double-ended queue.
// No dependencies; used by circular_double_ended_queue and its testbench.
package cdq_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 4;
    localparam int DEFAULT_DEPTH = 8;
    localparam int S_TDATA_W     = 40;   // 35 bits of fields, padded to bytes
    localparam int M_TDATA_W     = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_REAR  = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE       = 2'd0,
        STAT_PUSH_FULL  = 2'd1,
        STAT_POP_EMPTY  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP_RD
    } state_t;

endpackage

// ===== sv/cdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/circular_double_ended_queue.sv =====
// Top level of the circular double-ended queue: control, pointers, result register.
// Depends on cdq_pkg and cdq_ram.
//
//  channel | dir | handshake          | payload (low bit first)
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | command[2:0], push_value[34:3], zero pad
//  m_      | out | m_tvalid/m_tready  | pop_value[31:0], status[33:32], is_full[34],
//          |     |                    | is_empty[35], occupancy[39:36]
//
// Push, refused request and status query go straight to the result register;
//   a successful pop first passes through ST_POP_RD for the registered RAM read.
// One request is in flight at a time; s_tready drops while a pop read is pending.
// A new request is taken while the previous result is being handed off (m_tready).
// Reset (aresetn low, synchronous) empties the queue; RAM contents are not cleared.
// A stalled result holds m_tdata and m_tvalid until m_tready.
module circular_double_ended_queue #(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,   // command, push_value, pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdq_pkg::M_TDATA_W-1:0] m_tdata    // pop_value, status, is_full,
                                                     // is_empty, occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    cdq_pkg::state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    // Result register, split so a pop can fill the data in the cycle after its status
    logic                          out_valid_reg, out_valid_next;
    logic [cdq_pkg::DATA_W-1:0]    out_data_reg, out_data_next;
    cdq_pkg::status_t              out_status_reg, out_status_next;
    logic                          out_full_reg, out_full_next;
    logic                          out_empty_reg, out_empty_next;
    logic [cdq_pkg::OCC_W-1:0]     out_occ_reg, out_occ_next;

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    cdq_pkg::cmd_t              cmd;
    logic [cdq_pkg::DATA_W-1:0] push_value;
    logic                       accept;
    logic                       is_push, is_pop, is_front;
    logic                       q_empty, q_full;
    logic                       push_ok, pop_ok;

    assign cmd        = cdq_pkg::cmd_t'(s_tdata[cdq_pkg::CMD_W-1:0]);
    assign push_value = s_tdata[cdq_pkg::CMD_W +: cdq_pkg::DATA_W];
    assign accept     = s_tvalid && s_tready;

    assign is_push  = (cmd == cdq_pkg::CMD_PUSH_REAR) || (cmd == cdq_pkg::CMD_PUSH_FRONT);
    assign is_pop   = (cmd == cdq_pkg::CMD_POP_FRONT) || (cmd == cdq_pkg::CMD_POP_REAR);
    assign is_front = (cmd == cdq_pkg::CMD_PUSH_FRONT) || (cmd == cdq_pkg::CMD_POP_FRONT);
    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == FULL_CNT);
    assign push_ok  = is_push && !q_full;
    assign pop_ok   = is_pop && !q_empty;

    // Wrapped neighbors of the pointers
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    // ---------------------------------------------------------------
    // Ring store
    // ---------------------------------------------------------------
    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [cdq_pkg::DATA_W-1:0] ram_rdata;

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cdq_pkg::ST_IDLE: begin
                if (accept && pop_ok) begin
                    state_next = cdq_pkg::ST_POP_RD;
                end
            end
            cdq_pkg::ST_POP_RD: begin
                state_next = cdq_pkg::ST_IDLE;
            end
            default: begin
                state_next = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs of the state machine: handshake and RAM port
    // ---------------------------------------------------------------
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = tail_inc;
        ram_raddr = is_front ? head_reg : tail_reg;
        unique case (state_reg)
            cdq_pkg::ST_IDLE: begin
                // result slot is free, or is being handed off this cycle
                s_tready = !out_valid_reg || m_tready;
                ram_we   = accept && push_ok;
                ram_re   = accept && pop_ok;
                if (q_empty) begin
                    ram_waddr = '0;
                end else if (is_front) begin
                    ram_waddr = head_dec;
                end
            end
            cdq_pkg::ST_POP_RD: begin
                s_tready = 1'b0;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Pointer and count update
    // ---------------------------------------------------------------
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (accept && push_ok) begin
            count_next = count_reg + 1'b1;
            if (q_empty) begin
                head_next = '0;
                tail_next = '0;
            end else if (is_front) begin
                head_next = head_dec;
            end else begin
                tail_next = tail_inc;
            end
        end else if (accept && pop_ok) begin
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1)) begin
                // last element leaves: back to the reset layout
                head_next = '0;
                tail_next = '0;
            end else if (is_front) begin
                head_next = head_inc;
            end else begin
                tail_next = tail_dec;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_full_next   = out_full_reg;
        out_empty_next  = out_empty_reg;
        out_occ_next    = out_occ_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            // status fields are known at once; popped data arrives next cycle
            out_data_next = '0;
            if (is_push && q_full) begin
                out_status_next = cdq_pkg::STAT_PUSH_FULL;
            end else if (is_pop && q_empty) begin
                out_status_next = cdq_pkg::STAT_POP_EMPTY;
            end else begin
                out_status_next = cdq_pkg::STAT_DONE;
            end
            out_full_next  = (count_next == FULL_CNT);
            out_empty_next = (count_next == '0);
            out_occ_next   = cdq_pkg::OCC_W'(count_next);
            out_valid_next = !pop_ok;
        end

        if (state_reg == cdq_pkg::ST_POP_RD) begin
            out_data_next  = ram_rdata;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cdq_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_full_reg   <= out_full_next;
        out_empty_reg  <= out_empty_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_occ_reg, out_empty_reg, out_full_reg, out_status_reg, out_data_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("element count exceeds depth");

    a_pop_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == cdq_pkg::ST_POP_RD |-> !out_valid_reg)
        else $error("pop read pending while result register still occupied");

    a_pop_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pop_ok |=> state_reg == cdq_pkg::ST_POP_RD ##1 out_valid_reg)
        else $error("successful pop did not deliver its result after the read");

    a_empty_layout: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> head_reg == '0 && tail_reg == '0)
        else $error("empty queue with pointers away from slot zero");

endmodule

// ===== tb/circular_double_ended_queue_tb.sv =====
`timescale 1ns / 100ps
// Testbench for circular_double_ended_queue: directed table, then biased random commands.
// Depends on cdq_pkg and the block's RTL; self-checking through a built-in deque predictor.
module circular_double_ended_queue_tb;

    localparam int DEPTH        = cdq_pkg::DEFAULT_DEPTH;
    localparam int FIELD_W      = cdq_pkg::DATA_W;   // width used when comparing fields
    localparam int RANDOM_ITEMS = 625;
    localparam int STALL_LIMIT  = 1000;   // cycles with no request moving on either side
    localparam int HOLD_AT      = 200;    // result count at which the sink holds off
    localparam int HOLD_CYCLES  = 150;
    localparam int PAUSE_AT     = 300;    // random request index where the source drains

    // command codes the package leaves unnamed; the block treats them as a query
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // laid out exactly as m_tdata, highest field first
    typedef struct packed {
        logic [cdq_pkg::OCC_W-1:0]  occupancy;
        logic                       is_empty;
        logic                       is_full;
        cdq_pkg::status_t           status;
        logic [cdq_pkg::DATA_W-1:0] pop_value;
    } outcome_t;

    typedef struct packed {
        logic [cdq_pkg::CMD_W-1:0]  cmd;
        logic [cdq_pkg::DATA_W-1:0] value;
        logic                       fixed_exp;   // 1: use want, 0: use the predictor
        outcome_t                   want;
    } row_t;

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [cdq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cdq_pkg::M_TDATA_W-1:0] m_tdata;

    circular_double_ended_queue #(.DEPTH(DEPTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor state: ring contents, front/rear slot, empty flag
    // ---------------------------------------------------------------
    logic [cdq_pkg::DATA_W-1:0] deque_ring [DEPTH];
    int                         front_idx   = 0;
    int                         rear_idx    = 0;
    bit                         deque_empty = 1'b1;

    outcome_t outcome_q [$];      // expected results, oldest first
    int       error_count  = 0;
    int       results_seen = 0;
    bit       tx_calm      = 1'b0;   // source runs without gaps while set
    bit       rx_calm      = 1'b0;   // sink runs without stalls while set

    function automatic int deque_count();
        if (deque_empty)
            return 0;
        return ((rear_idx + DEPTH - front_idx) % DEPTH) + 1;
    endfunction

    // Apply one command to the predictor and return what the block should report.
    function automatic outcome_t predict_outcome(input logic [cdq_pkg::CMD_W-1:0] cmd,
                                                 input logic [cdq_pkg::DATA_W-1:0] val);
        outcome_t o;
        int       held;
        o        = '0;
        o.status = cdq_pkg::STAT_DONE;
        if (cmd == cdq_pkg::CMD_PUSH_REAR || cmd == cdq_pkg::CMD_PUSH_FRONT) begin
            if (deque_count() == DEPTH) begin
                o.status = cdq_pkg::STAT_PUSH_FULL;
            end else if (deque_empty) begin
                // first element always lands in slot 0
                front_idx     = 0;
                rear_idx      = 0;
                deque_empty   = 1'b0;
                deque_ring[0] = val;
            end else if (cmd == cdq_pkg::CMD_PUSH_REAR) begin
                rear_idx             = (rear_idx + 1) % DEPTH;
                deque_ring[rear_idx] = val;
            end else begin
                front_idx             = (front_idx + DEPTH - 1) % DEPTH;
                deque_ring[front_idx] = val;
            end
        end else if (cmd == cdq_pkg::CMD_POP_FRONT || cmd == cdq_pkg::CMD_POP_REAR) begin
            if (deque_empty) begin
                o.status = cdq_pkg::STAT_POP_EMPTY;
            end else begin
                o.pop_value = (cmd == cdq_pkg::CMD_POP_FRONT) ? deque_ring[front_idx]
                                                              : deque_ring[rear_idx];
                if (front_idx == rear_idx) begin
                    // last element gone: pointers go back home
                    front_idx   = 0;
                    rear_idx    = 0;
                    deque_empty = 1'b1;
                end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
                    front_idx = (front_idx + 1) % DEPTH;
                end else begin
                    rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
                end
            end
        end
        held        = deque_count();
        o.is_full   = (held == DEPTH);
        o.is_empty  = deque_empty;
        o.occupancy = held[cdq_pkg::OCC_W-1:0];
        return o;
    endfunction

    function automatic outcome_t mk_out(input logic [cdq_pkg::DATA_W-1:0] pop,
                                        input cdq_pkg::status_t st,
                                        input logic full, input logic empty,
                                        input logic [cdq_pkg::OCC_W-1:0] occ);
        outcome_t o;
        o.pop_value = pop;
        o.status    = st;
        o.is_full   = full;
        o.is_empty  = empty;
        o.occupancy = occ;
        return o;
    endfunction

    function automatic row_t mk_row(input logic [cdq_pkg::CMD_W-1:0] cmd,
                                    input logic [cdq_pkg::DATA_W-1:0] val,
                                    input logic fixed_exp, input outcome_t want);
        row_t r;
        r.cmd       = cmd;
        r.value     = val;
        r.fixed_exp = fixed_exp;
        r.want      = want;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Source side. Leaves s_tvalid high after acceptance so a zero gap
    // keeps requests back to back.
    // ---------------------------------------------------------------
    task automatic send_request(input logic [cdq_pkg::CMD_W-1:0] cmd,
                                input logic [cdq_pkg::DATA_W-1:0] val,
                                input logic fixed_exp, input outcome_t want);
        int       gap;
        outcome_t pred;
        if ($urandom_range(0, 29) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cdq_pkg::S_TDATA_W - cdq_pkg::DATA_W - cdq_pkg::CMD_W){1'b0}},
                     val, cmd};
        do @(posedge aclk); while (!s_tready);
        // request taken at this edge; the predictor always advances
        pred = predict_outcome(cmd, val);
        outcome_q.push_back(fixed_exp ? want : pred);
    endtask

    // Called right after an acceptance: drop valid, then wait until all results are back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic flag_field(input string name, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Sink side: random stalls, one long hold-off to back up the block
    // ---------------------------------------------------------------
    initial begin : result_sink
        int       gap;
        bit       held_long;
        outcome_t got;
        outcome_t want;
        held_long = 1'b0;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 29) == 0)
                rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 19);
            if (!held_long && results_seen >= HOLD_AT) begin
                gap       = HOLD_CYCLES;
                held_long = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = outcome_t'(m_tdata);
            results_seen++;
            if (outcome_q.size() == 0) begin
                $display("%0t: result with no request waiting, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                flag_field("pop_value", want.pop_value, got.pop_value);
                flag_field("status",    FIELD_W'(want.status),    FIELD_W'(got.status));
                flag_field("is_full",   FIELD_W'(want.is_full),   FIELD_W'(got.is_full));
                flag_field("is_empty",  FIELD_W'(want.is_empty),  FIELD_W'(got.is_empty));
                flag_field("occupancy", FIELD_W'(want.occupancy), FIELD_W'(got.occupancy));
            end
        end
    end

    // Watchdog: nothing moving on either channel for too long ends the run.
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("circular_double_ended_queue: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: directed table, then biased random commands
    // ---------------------------------------------------------------
    initial begin : stimulus
        row_t                       dir_rows [$];
        outcome_t                   none;
        logic [cdq_pkg::CMD_W-1:0]  cmd;
        logic [cdq_pkg::DATA_W-1:0] val;
        int                         push_bias;
        int                         phase_left;
        int                         pick;

        none = '0;

        // empty queue: both pops refused, query reports empty
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_FRONT, 32'h1234_5678, 1'b1,
                                  mk_out('0, cdq_pkg::STAT_POP_EMPTY, 1'b0, 1'b1, 4'd0)));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_REAR, 32'hFFFF_FFFF, 1'b1,
                                  mk_out('0, cdq_pkg::STAT_POP_EMPTY, 1'b0, 1'b1, 4'd0)));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_QUERY, 32'hFFFF_FFFF, 1'b1,
                                  mk_out('0, cdq_pkg::STAT_DONE, 1'b0, 1'b1, 4'd0)));
        // value extremes in and out at both ends
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_REAR, 32'h7FFF_FFFF, 1'b1,
                                  mk_out('0, cdq_pkg::STAT_DONE, 1'b0, 1'b0, 4'd1)));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1,
                                  mk_out('0, cdq_pkg::STAT_DONE, 1'b0, 1'b0, 4'd2)));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_FRONT, 32'h0, 1'b1,
                                  mk_out(32'h8000_0000, cdq_pkg::STAT_DONE, 1'b0, 1'b0,
                                         4'd1)));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_REAR, 32'h0, 1'b1,
                                  mk_out(32'h7FFF_FFFF, cdq_pkg::STAT_DONE, 1'b0, 1'b1,
                                         4'd0)));
        // fill to DEPTH from both ends, wrapping the front pointer
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_REAR,  32'h0000_0000, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_REAR,  32'h8000_0000, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_FRONT, 32'h5555_5555, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_REAR,  32'hDEAD_BEEF, 1'b0, none));
        // full queue: pushes at either end refused
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_REAR, 32'hFFFF_FFFF, 1'b1,
                                  mk_out('0, cdq_pkg::STAT_PUSH_FULL, 1'b1, 1'b0, 4'd8)));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 1'b1,
                                  mk_out('0, cdq_pkg::STAT_PUSH_FULL, 1'b1, 1'b0, 4'd8)));
        // spare command codes behave as a query
        dir_rows.push_back(mk_row(CMD_SPARE_5, 32'hFFFF_FFFF, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_SPARE_6, 32'h0000_0000, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_SPARE_7, 32'h8000_0001, 1'b0, none));
        // unload from both ends
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_REAR,  32'h0, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_FRONT, 32'h0, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_FRONT, 32'h0, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_POP_REAR,  32'h0, 1'b0, none));
        dir_rows.push_back(mk_row(cdq_pkg::CMD_QUERY,     32'h0, 1'b0, none));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].fixed_exp,
                         dir_rows[i].want);
        drain_results();

        // Random part: phases of push-heavy and pop-heavy traffic so that the
        // queue keeps running into both its full and its empty boundary.
        push_bias  = 80;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 4))
                    0: push_bias = 90;
                    1: push_bias = 10;
                    2: push_bias = 50;
                    3: push_bias = 70;
                    default: push_bias = 30;
                endcase
                phase_left = $urandom_range(15, 50);
            end
            phase_left--;

            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_SPARE_5;
                    1: cmd = CMD_SPARE_6;
                    default: cmd = CMD_SPARE_7;
                endcase
            end else if (pick < 12) begin
                cmd = cdq_pkg::CMD_QUERY;
            end else if ($urandom_range(0, 99) < push_bias) begin
                cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_REAR
                                           : cdq_pkg::CMD_PUSH_FRONT;
            end else begin
                cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_FRONT
                                           : cdq_pkg::CMD_POP_REAR;
            end

            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: val = 32'h0000_0000;
                    1: val = 32'hFFFF_FFFF;
                    2: val = 32'h7FFF_FFFF;
                    default: val = 32'h8000_0000;
                endcase
            end else begin
                val = $urandom;
            end

            send_request(cmd, val, 1'b0, none);
            if (n == PAUSE_AT)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge aclk);   // catch any stray result after the last one

        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("circular_double_ended_queue: match");
        end else begin
            $display("circular_double_ended_queue: mismatch");
        end
        $finish;
    end

endmodule
